// ===== design/i2c_motor_command_controller_assert.svh =====
// assertion macros shared by the motor command controller
`ifndef I2C_MOTOR_COMMAND_CONTROLLER_ASSERT_SVH
`define I2C_MOTOR_COMMAND_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IMCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imcc same-cycle check failed");

// next-cycle implication, checked outside reset
`define IMCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imcc next-cycle check failed");

`endif

// ===== design/imcc_pkg.sv =====
// types, codes and reset constants of the motor command controller
`timescale 1ns / 1ps

package imcc_pkg;

  // command buffer depth default
  localparam int CMD_DEPTH_DEFAULT = 4;

  // register file addressing
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_DEVICE_ID     = 3'd0;
  localparam logic [2:0] REG_SLOW_BLINK    = 3'd1;
  localparam logic [2:0] REG_FAST_BLINK    = 3'd2;
  localparam logic [2:0] REG_BATT_THRESH   = 3'd3;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd4;
  localparam logic [2:0] REG_LONG_PRESS    = 3'd5;

  // register reset values
  localparam logic [6:0]  DEVICE_ID_RST     = 7'h0f;
  localparam logic [15:0] SLOW_BLINK_RST    = 16'd500;
  localparam logic [15:0] FAST_BLINK_RST    = 16'd200;
  localparam logic [9:0]  BATT_THRESH_RST   = 10'd600;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd5000;
  localparam logic [15:0] LONG_PRESS_RST    = 16'd3000;

  // first LED toggle time after reset
  localparam logic [31:0] LED_DEADLINE_RST = 32'd500;

  // event codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_WR_ADDR  = 3'd1;
  localparam logic [2:0] OP_WR_BYTE  = 3'd2;
  localparam logic [2:0] OP_RD_ADDR  = 3'd3;
  localparam logic [2:0] OP_RD_BYTE  = 3'd4;
  localparam logic [2:0] OP_STOP     = 3'd5;
  localparam logic [2:0] OP_SAMPLE   = 3'd6;

  // command codes
  localparam logic [7:0] CMD_IDENTIFY  = 8'h00;
  localparam logic [7:0] CMD_BATTERY   = 8'h01;
  localparam logic [7:0] CMD_UPTIME    = 8'h02;
  localparam logic [7:0] CMD_POWER_OFF = 8'h0f;
  localparam logic [7:0] CMD_PHASE_A0  = 8'h10;
  localparam logic [7:0] CMD_PHASE_A1  = 8'h11;
  localparam logic [7:0] CMD_DUTY_A    = 8'h12;
  localparam logic [7:0] CMD_PHASE_B0  = 8'h20;
  localparam logic [7:0] CMD_PHASE_B1  = 8'h21;
  localparam logic [7:0] CMD_DUTY_B    = 8'h22;
  localparam logic [7:0] CMD_FRONT0    = 8'h30;
  localparam logic [7:0] CMD_FRONT1    = 8'h31;
  localparam logic [7:0] CMD_BACK0     = 8'h32;
  localparam logic [7:0] CMD_BACK1     = 8'h33;

  // number of reply bytes
  localparam logic [2:0] REPLY_BYTES = 3'd4;

  // configuration as seen by the core
  typedef struct packed {
    logic [6:0]  device_id;
    logic [15:0] slow_blink_ms;
    logic [15:0] fast_blink_ms;
    logic [9:0]  battery_threshold;
    logic [15:0] sample_period_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  // one input event
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic [9:0] battery_sample;
    logic       switch_level;
  } event_t;

  // one result
  typedef struct packed {
    logic [7:0] read_byte;
    logic       phase_a;
    logic       phase_b;
    logic [7:0] duty_a_out;
    logic [7:0] duty_b_out;
    logic       front_out;
    logic       back_out;
    logic       led_out;
    logic       power_hold;
    logic       sample_request;
  } result_t;

  // output latches
  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic       phase_a;
    logic       phase_b;
    logic       front;
    logic       back;
    logic       led;
    logic       power_hold;
  } latch_t;

  localparam latch_t LATCH_RST = '{duty_a: 8'd0, duty_b: 8'd0, phase_a: 1'b0,
                                   phase_b: 1'b0, front: 1'b0, back: 1'b0,
                                   led: 1'b0, power_hold: 1'b1};

endpackage

// ===== design/i2c_motor_command_controller.sv =====
// Motor command controller fed by I2C client events, ticks and battery samples.
//
// Event channel: event_valid/event_stall/event_data carry one event request
// (tick, write address, write byte, read address, read byte, stop, sample).
// Result channel: result_valid/result_stall/result_data return exactly one
// result request per event: the reply byte, the motor, lamp, LED and power
// latches after the event, and the sample request flag.
// An event taken into the input register is processed by the core as it
// moves on, and its result is then offered from the result register.
// Throughput is one event per cycle while the receiver does not stall,
// limited only by the single update pass of the core between the input
// register and the result register. When the receiver stalls, the result
// register holds; one more event waits in the input register, after which
// event_stall rises. Synchronous reset clears both registers, the
// controller state and loads the register defaults. The register port
// writes in the access phase, pready is always high; the user must change
// registers only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module i2c_motor_command_controller
  import imcc_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              event_valid,
  output logic              event_stall,
  input  event_t            event_data,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

`include "i2c_motor_command_controller_assert.svh"

  cfg_t    cfg;
  logic    held_valid;
  event_t  held_item;
  logic    move;
  result_t core_result;

  assign pready      = 1'b1;
  assign move        = held_valid & ~(result_valid & result_stall);
  assign event_stall = held_valid & result_valid & result_stall;

  // configuration registers
  imcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // event processing
  imcc_core #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (move),
    .item   (held_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (event_valid && !event_stall) begin
      held_valid <= 1'b1;
    end else if (move) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (event_valid && !event_stall) begin
      held_item <= event_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result_data <= core_result;
    end
  end

  // checks
  `IMCC_ASSERT_IMPLY(a_stall_needs_held, clk, rst, event_stall, held_valid && result_valid)
  `IMCC_ASSERT_NEXT(a_move_gives_result, clk, rst, move, result_valid)
  `IMCC_ASSERT_IMPLY(a_off_led_dark, clk, rst, result_valid && !result_data.power_hold,
                     !result_data.led_out)

endmodule

// ===== design/imcc_regs.sv =====
// configuration register file behind the bus port
`timescale 1ns / 1ps

module imcc_regs
  import imcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] index;

  assign wr_en = psel & penable & pwrite;
  assign index = paddr[ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_id         <= DEVICE_ID_RST;
      cfg.slow_blink_ms     <= SLOW_BLINK_RST;
      cfg.fast_blink_ms     <= FAST_BLINK_RST;
      cfg.battery_threshold <= BATT_THRESH_RST;
      cfg.sample_period_ms  <= SAMPLE_PERIOD_RST;
      cfg.long_press_ms     <= LONG_PRESS_RST;
    end else if (wr_en) begin
      case (index)
        REG_DEVICE_ID:     cfg.device_id         <= pwdata[6:0];
        REG_SLOW_BLINK:    cfg.slow_blink_ms     <= pwdata[15:0];
        REG_FAST_BLINK:    cfg.fast_blink_ms     <= pwdata[15:0];
        REG_BATT_THRESH:   cfg.battery_threshold <= pwdata[9:0];
        REG_SAMPLE_PERIOD: cfg.sample_period_ms  <= pwdata[15:0];
        REG_LONG_PRESS:    cfg.long_press_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (index)
      REG_DEVICE_ID:     prdata = {25'd0, cfg.device_id};
      REG_SLOW_BLINK:    prdata = {16'd0, cfg.slow_blink_ms};
      REG_FAST_BLINK:    prdata = {16'd0, cfg.fast_blink_ms};
      REG_BATT_THRESH:   prdata = {22'd0, cfg.battery_threshold};
      REG_SAMPLE_PERIOD: prdata = {16'd0, cfg.sample_period_ms};
      REG_LONG_PRESS:    prdata = {16'd0, cfg.long_press_ms};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== design/imcc_core.sv =====
// controller state and the per-event update logic
`timescale 1ns / 1ps

module imcc_core
  import imcc_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  event_t  item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int IDX_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  // state
  logic [31:0]      uptime;
  logic [7:0]       cmd [CMD_DEPTH];
  logic [CNT_W-1:0] rx_count;
  logic [31:0]      reply_word;
  logic [2:0]       reply_index;
  logic [31:0]      led_deadline;
  logic             battery_low;
  logic [9:0]       battery_value;
  logic [31:0]      sample_deadline;
  logic [31:0]      press_deadline;
  logic             switch_before;
  latch_t           latches;

  // next values
  logic [31:0]      uptime_next;
  logic [CNT_W-1:0] rx_count_next;
  logic [31:0]      reply_word_next;
  logic [2:0]       reply_index_next;
  logic [31:0]      led_deadline_next;
  logic             battery_low_next;
  logic [9:0]       battery_value_next;
  logic [31:0]      sample_deadline_next;
  logic [31:0]      press_deadline_next;
  logic             switch_before_next;
  latch_t           latches_next;
  logic             cmd_we;
  logic [7:0]       rd;
  logic             req;
  logic [31:0]      uptime_inc;
  logic [15:0]      blink_period;

  assign uptime_inc   = uptime + 32'd1;
  assign blink_period = battery_low ? cfg.fast_blink_ms : cfg.slow_blink_ms;

  // event decode and state update
  always_comb begin
    uptime_next          = uptime;
    rx_count_next        = rx_count;
    reply_word_next      = reply_word;
    reply_index_next     = reply_index;
    led_deadline_next    = led_deadline;
    battery_low_next     = battery_low;
    battery_value_next   = battery_value;
    sample_deadline_next = sample_deadline;
    press_deadline_next  = press_deadline;
    switch_before_next   = switch_before;
    latches_next         = latches;
    cmd_we               = 1'b0;
    rd                   = 8'd0;
    req                  = 1'b0;
    if (latches.power_hold) begin
      case (item.operation)
        OP_TICK: begin
          uptime_next = uptime_inc;
          // led blink
          if (uptime_inc >= led_deadline) begin
            led_deadline_next = led_deadline + {16'd0, blink_period};
            latches_next.led  = ~latches.led;
          end
          // periodic sample request
          if (sample_deadline <= uptime_inc) begin
            sample_deadline_next = uptime_inc + {16'd0, cfg.sample_period_ms};
            req                  = 1'b1;
          end
          // switch edge or long press
          if (item.switch_level != switch_before) begin
            switch_before_next = item.switch_level;
            if (!item.switch_level) begin
              press_deadline_next = uptime_inc + {16'd0, cfg.long_press_ms};
            end
          end else if (!item.switch_level && uptime_inc >= press_deadline) begin
            latches_next.led        = 1'b0;
            latches_next.power_hold = 1'b0;
          end
        end
        OP_WR_ADDR: begin
          rx_count_next = '0;
        end
        OP_WR_BYTE: begin
          if (rx_count < CNT_W'(CMD_DEPTH)) begin
            cmd_we        = 1'b1;
            rx_count_next = rx_count + CNT_W'(1);
          end
        end
        OP_RD_BYTE: begin
          if (reply_index < REPLY_BYTES) begin
            rd               = 8'(reply_word >> {reply_index[1:0], 3'b000});
            reply_index_next = reply_index + 3'd1;
          end
        end
        OP_STOP: begin
          if (rx_count != '0) begin
            reply_index_next = 3'd0;
            case (cmd[0])
              CMD_IDENTIFY:  reply_word_next = {25'd0, cfg.device_id};
              CMD_BATTERY:   reply_word_next = {22'd0, battery_value};
              CMD_UPTIME:    reply_word_next = uptime;
              CMD_POWER_OFF: begin
                latches_next.led        = 1'b0;
                latches_next.power_hold = 1'b0;
              end
              CMD_PHASE_A0:  latches_next.phase_a = 1'b0;
              CMD_PHASE_A1:  latches_next.phase_a = 1'b1;
              CMD_DUTY_A:    latches_next.duty_a  = cmd[1];
              CMD_PHASE_B0:  latches_next.phase_b = 1'b0;
              CMD_PHASE_B1:  latches_next.phase_b = 1'b1;
              CMD_DUTY_B:    latches_next.duty_b  = cmd[1];
              CMD_FRONT0:    latches_next.front   = 1'b0;
              CMD_FRONT1:    latches_next.front   = 1'b1;
              CMD_BACK0:     latches_next.back    = 1'b0;
              CMD_BACK1:     latches_next.back    = 1'b1;
              default: ;
            endcase
          end
        end
        OP_SAMPLE: begin
          battery_value_next = item.battery_sample;
          battery_low_next   = item.battery_sample < cfg.battery_threshold;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      uptime          <= '0;
      rx_count        <= '0;
      reply_word      <= '0;
      reply_index     <= '0;
      led_deadline    <= LED_DEADLINE_RST;
      battery_low     <= 1'b0;
      battery_value   <= '0;
      sample_deadline <= '0;
      press_deadline  <= '0;
      switch_before   <= 1'b1;
      latches         <= LATCH_RST;
    end else if (fire) begin
      uptime          <= uptime_next;
      rx_count        <= rx_count_next;
      reply_word      <= reply_word_next;
      reply_index     <= reply_index_next;
      led_deadline    <= led_deadline_next;
      battery_low     <= battery_low_next;
      battery_value   <= battery_value_next;
      sample_deadline <= sample_deadline_next;
      press_deadline  <= press_deadline_next;
      switch_before   <= switch_before_next;
      latches         <= latches_next;
    end
  end

  // command byte buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CMD_DEPTH; i++) begin
        cmd[i] <= 8'd0;
      end
    end else if (fire && cmd_we) begin
      cmd[rx_count[IDX_W-1:0]] <= item.data_byte;
    end
  end

  // result assembly
  assign result = '{read_byte:      rd,
                    phase_a:        latches_next.phase_a,
                    phase_b:        latches_next.phase_b,
                    duty_a_out:     latches_next.duty_a,
                    duty_b_out:     latches_next.duty_b,
                    front_out:      latches_next.front,
                    back_out:       latches_next.back,
                    led_out:        latches_next.led,
                    power_hold:     latches_next.power_hold,
                    sample_request: req};

endmodule
